### rtl/core/sfib_pkg.sv
// Shared types, constants and helper functions for the horizontal span fill block.
// No dependencies; imported by every module of the block.
package sfib_pkg;

  // Number of visible rows; rows at or past this value are dropped.
  localparam int unsigned ROWS = 192;
  localparam logic [8:0]  ROWS_LIM = 9'(ROWS);

  localparam int unsigned ADDR_W = 13;
  localparam logic [7:0]  BYTE_FULL = 8'hFF;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } sfib_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;   // capture a kept request
    logic step;   // one byte write has been transferred
  } sfib_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic keep;   // presented request survives the drop checks
    logic last;   // current byte write is the final one of the span
  } sfib_sts_t;

  // Interleaved row: keep the third, swap the pixel-line and character-row bits.
  function automatic logic [7:0] interleave_row(input logic [7:0] y);
    interleave_row = {y[7:6], y[2:0], y[5:3]};
  endfunction

  // Pixels 0..r of a byte, counted from the MSB.
  function automatic logic [7:0] right_mask(input logic [2:0] r);
    logic [15:0] w;
    w = 16'hFF00 >> ({1'b0, r} + 4'd1);
    right_mask = w[7:0];
  endfunction

endpackage

### rtl/core/sfib_dp.sv
// Datapath of the span fill block: drop checks, clip, address and mask generation.
// Depends on sfib_pkg.
module sfib_dp
  import sfib_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic [7:0]          in_right_x,
  input  logic [7:0]          in_row_y,
  input  logic [7:0]          in_span_len,
  input  sfib_cmd_t           cmd,
  output sfib_sts_t           sts,
  output logic [ADDR_W-1:0]   out_byte_addr,
  output logic [7:0]          out_byte_data,
  output logic                out_last_write
);

  logic [7:0]        last_row_r, last_row_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [7:0]        rem_r, rem_nxt;
  logic [2:0]        r_r, r_nxt;

  logic [7:0] len_clip;
  logic [7:0] r_plus1;
  logic       fits;
  logic [3:0] sh;
  logic [7:0] rmask;

  always_comb begin
    // Clip at the left edge: at most right_x + 1 pixels.
    len_clip = (in_span_len > in_right_x) ? (in_right_x + 8'd1) : in_span_len;
  end

  // Current write: the remaining pixels fit within columns 0..r of this byte.
  always_comb begin
    sts.keep = ({1'b0, in_row_y} < ROWS_LIM) && (in_row_y != last_row_r)
               && (in_span_len != 8'd0);
    r_plus1 = {5'd0, r_r} + 8'd1;
    fits    = (rem_r <= r_plus1);
    sh      = r_plus1[3:0] - rem_r[3:0];
    rmask   = right_mask(r_r);
    sts.last       = fits;
    out_last_write = fits;
    out_byte_addr  = addr_r;
    out_byte_data  = fits ? (rmask & (BYTE_FULL >> sh)) : rmask;
  end

  always_comb begin
    last_row_nxt = last_row_r;
    addr_nxt     = addr_r;
    rem_nxt      = rem_r;
    r_nxt        = r_r;
    if (cmd.load) begin
      last_row_nxt = in_row_y;
      addr_nxt     = {interleave_row(in_row_y), in_right_x[7:3]};
      rem_nxt      = len_clip;
      r_nxt        = in_right_x[2:0];
    end else if (cmd.step) begin
      // Advance one byte left; every later byte starts at its rightmost pixel.
      addr_nxt = addr_r - ADDR_W'(1);
      rem_nxt  = rem_r - r_plus1;
      r_nxt    = 3'd7;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_row_r <= 8'd0;
    end else begin
      last_row_r <= last_row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    rem_r  <= rem_nxt;
    r_r    <= r_nxt;
  end

endmodule

### rtl/core/sfib_ctrl.sv
// Controller of the span fill block: idle/emit state machine and handshakes.
// Depends on sfib_pkg.
module sfib_ctrl
  import sfib_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  sfib_sts_t sts,
  output sfib_cmd_t cmd
);

  sfib_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && sts.keep) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_stall && sts.last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    out_valid = 1'b0;
    cmd.load  = 1'b0;
    cmd.step  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid && sts.keep;
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        cmd.step  = !out_stall;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### rtl/core/span_fill_interleaved_bitmap.sv
// Top level of the horizontal span fill block for a 1-bit-per-pixel bitmap.
// Depends on sfib_pkg, sfib_ctrl and sfib_dp.
//
// Each input transfer requests span_len pixels in row row_y ending at column
// right_x and running left. The request is dropped (no output) when the row
// is at or past ROWS, when the count is zero, or when the row repeats the last
// kept row; that row resets to 0, so a first request for row 0 is dropped.
// A kept span is clipped at the left edge and becomes byte writes from right to
// left, one output transfer per cycle unless out_stall holds it, with a partial
// mask at each end, 0xFF in between, and last_write set on the final write.
// Address is interleaved row times 32 plus column byte. A span gives 1..32 byte
// writes; the input is stalled while writes are pending, since the byte counter
// and address register serve one span at a time.
module span_fill_interleaved_bitmap
  import sfib_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_right_x,
  input  logic [7:0]        in_row_y,
  input  logic [7:0]        in_span_len,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [ADDR_W-1:0] out_byte_addr,
  output logic [7:0]        out_byte_data,
  output logic              out_last_write
);

  sfib_cmd_t cmd;
  sfib_sts_t sts;

  // Sequence intake and write emission.
  sfib_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Hold span position and remaining count; drive the write payload.
  sfib_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_right_x     (in_right_x),
    .in_row_y       (in_row_y),
    .in_span_len    (in_span_len),
    .cmd            (cmd),
    .sts            (sts),
    .out_byte_addr  (out_byte_addr),
    .out_byte_data  (out_byte_data),
    .out_last_write (out_last_write)
  );

endmodule

### dv/testbench.sv
// Self-checking testbench for span_fill_interleaved_bitmap: span requests in, byte writes out.
// Depends on sfib_pkg and the span_fill_interleaved_bitmap RTL; needs no files or arguments.
module testbench;
  import sfib_pkg::*;

  // One span request waiting to be offered. drain holds the request back
  // until every predicted byte write has come out of the block.
  typedef struct {
    logic [7:0] rx;
    logic [7:0] y;
    logic [7:0] len;
    bit         drain;
  } span_req_t;

  // One predicted byte write.
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
    logic              last;
  } byte_write_t;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned QUIET_TAIL  = 60;   // items at the end sent without idling
  localparam int unsigned MAX_LINES   = 40;

  logic              clk;
  logic              rst_n          = 1'b0;
  logic              in_valid       = 1'b0;
  logic              in_stall;
  logic [7:0]        in_right_x     = '0;
  logic [7:0]        in_row_y       = '0;
  logic [7:0]        in_span_len    = '0;
  logic              out_valid;
  logic              out_stall      = 1'b0;
  logic [ADDR_W-1:0] out_byte_addr;
  logic [7:0]        out_byte_data;
  logic              out_last_write;

  span_req_t   span_q[$];        // requests not yet offered
  byte_write_t write_q[$];       // byte writes predicted but not yet seen
  logic [7:0]  kept_row = 8'd0;  // row of the last request the block keeps

  int unsigned total_spans;
  int unsigned spans_sent  = 0;
  int unsigned spans_taken = 0;
  int unsigned errors      = 0;
  int unsigned cycles      = 0;
  int unsigned send_gap    = 0;
  int unsigned stall_left  = 0;
  bit          drained     = 1'b1; // no byte write outstanding as of the last edge
  bit          hold_long   = 1'b0; // long receiver hold-off

  span_fill_interleaved_bitmap uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_right_x     (in_right_x),
    .in_row_y       (in_row_y),
    .in_span_len    (in_span_len),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte_addr  (out_byte_addr),
    .out_byte_data  (out_byte_data),
    .out_last_write (out_last_write)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report(input string msg);
    if (errors < MAX_LINES) begin
      $display("ERROR @%0t: %s", $realtime, msg);
    end
    errors++;
  endtask

  task automatic add_span(input logic [7:0] rx, input logic [7:0] y, input logic [7:0] len,
                          input bit drain);
    span_req_t s;
    s.rx    = rx;
    s.y     = y;
    s.len   = len;
    s.drain = drain;
    span_q.push_back(s);
  endtask

  // Work out the byte writes one accepted request produces and queue them.
  // Drop off-screen rows, empty spans and a repeat of the last kept row;
  // otherwise clip at column 0 and walk the bytes from right to left.
  task automatic plan_span(input logic [7:0] rx, input logic [7:0] y, input logic [7:0] len);
    int unsigned npix, col, r, full, tail, row_il;
    byte_write_t w;
    if (y >= ROWS || y == kept_row || len == 8'd0) return;
    kept_row = y;
    col  = rx;
    npix = len;
    if (col + 1 < npix) npix = col + 1;
    row_il = (y & 8'hC0) | ((y & 8'h07) << 3) | ((y & 8'h38) >> 3);
    w.addr = ADDR_W'(row_il * 32 + (col >> 3));
    r = col & 7;
    if (npix <= r + 1) begin
      // Whole span sits in one byte: mask both ends.
      w.data = 8'(((32'hFF00 >> (r + 1)) & 32'hFF) & (32'hFF >> (r + 1 - npix)));
      w.last = 1'b1;
      write_q.push_back(w);
      return;
    end
    w.data = 8'(32'hFF00 >> (r + 1));
    w.last = 1'b0;
    write_q.push_back(w);
    npix -= r + 1;
    full = npix >> 3;
    tail = npix & 7;
    for (int i = 0; i < full; i++) begin
      w.addr = w.addr - 1'b1;
      w.data = 8'hFF;
      w.last = (tail == 0 && i + 1 == full);
      write_q.push_back(w);
    end
    if (tail != 0) begin
      w.addr = w.addr - 1'b1;
      w.data = 8'((1 << tail) - 1);
      w.last = 1'b1;
      write_q.push_back(w);
    end
  endtask

  // Driver: advance to the next request once the current one is transferred
  // or nothing is offered. Idle in random bursts, except in every
  // third block of 50 requests and in the quiet tail of the run.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (span_q.size() == 0) begin
        in_valid <= 1'b0;
      end else if (span_q[0].drain && (in_valid || !drained)) begin
        // Pause: drained is registered, so it lags the last transfer.
        in_valid <= 1'b0;
      end else begin
        span_req_t s;
        s = span_q.pop_front();
        in_right_x  <= s.rx;
        in_row_y    <= s.y;
        in_span_len <= s.len;
        in_valid    <= 1'b1;
        spans_sent++;
        if (spans_sent + QUIET_TAIL < total_spans && (spans_sent / 50) % 3 != 2 &&
            $urandom_range(0, 3) == 0) begin
          send_gap <= $urandom_range(1, 8);
        end
      end
    end
  end

  // Receiver stall: random bursts, ORed with the long hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (spans_taken + QUIET_TAIL < total_spans && (spans_taken / 40) % 3 != 1 &&
                 $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 7);
      out_stall  <= 1'b1;
    end else begin
      out_stall  <= hold_long;
    end
  end

  // Monitor: predict on each request transfer, check each byte write transfer
  // against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        plan_span(in_right_x, in_row_y, in_span_len);
        spans_taken++;
      end
      if (out_valid === 1'b1 && out_stall == 1'b0) begin
        if (write_q.size() == 0) begin
          report($sformatf("unexpected write addr=%0h data=%0h last=%0b",
                           out_byte_addr, out_byte_data, out_last_write));
        end else begin
          byte_write_t w;
          w = write_q.pop_front();
          if (out_byte_addr !== w.addr)
            report($sformatf("byte_addr %0h, want %0h", out_byte_addr, w.addr));
          if (out_byte_data !== w.data)
            report($sformatf("byte_data %0h, want %0h (addr %0h)",
                             out_byte_data, w.data, w.addr));
          if (out_last_write !== w.last)
            report($sformatf("last_write %0b, want %0b (addr %0h)",
                             out_last_write, w.last, w.addr));
        end
      end
    end
    drained <= (write_q.size() == 0);
  end

  // Watchdog: stop a hung run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Long hold-off: stall the result side for a long stretch while requests
  // keep coming, so the block fills and stalls its input.
  initial begin
    wait (spans_taken >= 60);
    @(posedge clk);
    hold_long <= 1'b1;
    repeat (400) @(posedge clk);
    hold_long <= 1'b0;
  end

  initial begin
    logic [7:0] prev_y;
    logic [7:0] y;
    logic [7:0] len;
    int unsigned pick;

    // Directed spans.
    add_span(8'd10,  8'd0,   8'd5,   1'b0); // row 0 right after reset: dropped
    add_span(8'd255, 8'd191, 8'd255, 1'b0); // full width, bottom row: 32 writes
    add_span(8'd255, 8'd191, 8'd4,   1'b0); // same row again: dropped
    add_span(8'd100, 8'd192, 8'd10,  1'b0); // first row past the screen: dropped
    add_span(8'd100, 8'd255, 8'd10,  1'b0); // far past the screen: dropped
    add_span(8'd100, 8'd7,   8'd0,   1'b0); // empty span: dropped
    add_span(8'd3,   8'd5,   8'd200, 1'b0); // clipped at the left edge
    add_span(8'd0,   8'd1,   8'd1,   1'b0); // single leftmost pixel
    add_span(8'd0,   8'd0,   8'd255, 1'b0); // row 0 kept now, clipped to 1 pixel
    add_span(8'd13,  8'd2,   8'd3,   1'b0); // inside one byte, both ends masked
    add_span(8'd23,  8'd3,   8'd16,  1'b0); // left end on a byte boundary
    add_span(8'd20,  8'd4,   8'd5,   1'b0); // exactly fills to the byte start
    add_span(8'd20,  8'd6,   8'd6,   1'b0); // spills one pixel into the next byte
    add_span(8'd7,   8'd8,   8'd8,   1'b0); // one whole byte
    add_span(8'd255, 8'd63,  8'd1,   1'b0); // single rightmost pixel
    add_span(8'd128, 8'd64,  8'd128, 1'b1); // centre to one pixel short of the left edge, after a drain
    add_span(8'd254, 8'd128, 8'd255, 1'b0); // exactly reaches column 0
    add_span(8'd170, 8'd85,  8'd85,  1'b0);
    add_span(8'd85,  8'd170, 8'd170, 1'b0); // clipped
    add_span(8'd255, 8'd190, 8'd254, 1'b0);

    // Random spans: mostly kept rows, short and long lengths, with drops mixed in.
    prev_y = 8'd190;
    for (int i = 0; i < 360; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 5)       y = 8'($urandom_range(192, 255));
      else if (pick < 10) y = prev_y;
      else                y = 8'($urandom_range(0, 191));
      pick = $urandom_range(0, 99);
      if (pick < 3)       len = 8'd0;
      else if (pick < 50) len = 8'($urandom_range(1, 16));
      else if (pick < 85) len = 8'($urandom_range(17, 255));
      else                len = 8'($urandom_range(200, 255));
      add_span(8'($urandom_range(0, 255)), y, len, (i == 150 || i == 300));
      prev_y = y;
    end
    total_spans = span_q.size();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (!(spans_taken == total_spans && write_q.size() == 0)) @(posedge clk);
    repeat (40) @(posedge clk);

    if (write_q.size() != 0)
      report($sformatf("%0d byte writes never came out", write_q.size()));
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
